// File: rtl/core/assert_macros.svh
// assertion macros
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define ASSERT_IMPL(label, clk, rst, prop) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error("%m failed");
`define ASSERT_NEVER(label, clk, rst, cond) \
  label: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error("%m failed");
`else
`define ASSERT_IMPL(label, clk, rst, prop)
`define ASSERT_NEVER(label, clk, rst, cond)
`endif
`endif

// File: rtl/core/pitm_pkg.sv
package pitm_pkg;
  localparam int unsigned IDX_BITS = 12;
  localparam int unsigned CNT_BITS = 13;
  localparam int unsigned COORD_BITS = 16;
  localparam int unsigned MAX_VERTICES = 4096;
  localparam int unsigned MAX_TETRAS = 4096;
  localparam int unsigned DIFF_BITS = COORD_BITS + 1;
  localparam int unsigned PROD_BITS = 2 * DIFF_BITS;
  localparam int unsigned CROSS_BITS = PROD_BITS + 1;
  localparam int unsigned TERM_BITS = CROSS_BITS + DIFF_BITS;
  localparam int unsigned DET_BITS = TERM_BITS + 2;

  localparam logic [1:0] REQ_VERTEX = 2'd0;
  localparam logic [1:0] REQ_TETRA  = 2'd1;
  localparam logic [1:0] REQ_QUERY  = 2'd2;

  typedef logic signed [COORD_BITS-1:0] coord_t;
  typedef struct packed {
    coord_t x;
    coord_t y;
    coord_t z;
  } point_t;

  typedef struct packed {
    logic vtx_wr;
    logic tet_wr;
    logic start;
    logic idx_load;
    logic corner_fetch;
    logic [1:0] corner_sel;
    logic eval;
  } cmd_t;

  typedef struct packed {
    logic busy;
    logic done;
    logic result;
  } status_t;
endpackage

// File: rtl/core/pitm_datapath.sv
module pitm_datapath (
  input  logic                           clk,
  input  logic                           rst,
  input  pitm_pkg::cmd_t                 cmd,
  input  logic [pitm_pkg::IDX_BITS-1:0]  entry_index,
  input  pitm_pkg::point_t               pt_in,
  input  logic [4*pitm_pkg::IDX_BITS-1:0] corners_in,
  input  logic [pitm_pkg::CNT_BITS-1:0]  tetra_count,
  output pitm_pkg::status_t              status
);
  localparam int unsigned DB = pitm_pkg::DIFF_BITS;
  localparam int unsigned PB = pitm_pkg::PROD_BITS;
  localparam int unsigned CB = pitm_pkg::CROSS_BITS;
  localparam int unsigned TB = pitm_pkg::TERM_BITS;
  localparam int unsigned XB = pitm_pkg::DET_BITS;
  localparam int unsigned NS = 11;

  pitm_pkg::point_t vtx_mem [pitm_pkg::MAX_VERTICES];
  logic [4*pitm_pkg::IDX_BITS-1:0] tet_mem [pitm_pkg::MAX_TETRAS];

  pitm_pkg::point_t qpt;
  logic [pitm_pkg::IDX_BITS-1:0] tidx;
  logic [pitm_pkg::CNT_BITS-1:0] remain;
  logic [4*pitm_pkg::IDX_BITS-1:0] tet_rd;
  pitm_pkg::point_t vtx_rd;
  pitm_pkg::point_t c0, c1, c2;
  logic found;

  // pipeline: five orientation tests of one tetra in parallel
  logic signed [DB-1:0] s1_bx [5], s1_by [5], s1_bz [5];
  logic signed [DB-1:0] s1_cx [5], s1_cy [5], s1_cz [5];
  logic signed [DB-1:0] s1_ax [5], s1_ay [5], s1_az [5];
  logic signed [PB-1:0] s2_p [5][6];
  logic signed [DB-1:0] s2_ax [5], s2_ay [5], s2_az [5];
  logic signed [CB-1:0] s3_k [5][3];
  logic signed [DB-1:0] s3_ax [5], s3_ay [5], s3_az [5];
  logic signed [TB-1:0] s4_t [5][3];
  logic signed [XB-1:0] s5_d [5];
  logic [NS-1:0] vld;

  always_ff @(posedge clk) begin
    if (cmd.vtx_wr) vtx_mem[entry_index] <= pt_in;
    if (cmd.tet_wr) tet_mem[entry_index] <= corners_in;
    if (cmd.idx_load) tet_rd <= tet_mem[tidx];
    case (cmd.corner_sel)
      2'd0: vtx_rd <= vtx_mem[tet_rd[4*pitm_pkg::IDX_BITS-1 -: pitm_pkg::IDX_BITS]];
      2'd1: vtx_rd <= vtx_mem[tet_rd[3*pitm_pkg::IDX_BITS-1 -: pitm_pkg::IDX_BITS]];
      2'd2: vtx_rd <= vtx_mem[tet_rd[2*pitm_pkg::IDX_BITS-1 -: pitm_pkg::IDX_BITS]];
      default: vtx_rd <= vtx_mem[tet_rd[pitm_pkg::IDX_BITS-1:0]];
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.start) qpt <= pt_in;
  end

  // corner registers, shifted in as each vertex beat returns
  always_ff @(posedge clk) begin
    if (cmd.corner_fetch) begin
      c0 <= c1;
      c1 <= c2;
      c2 <= vtx_rd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tidx <= '0;
      remain <= '0;
    end else if (cmd.start) begin
      tidx <= '0;
      remain <= (tetra_count > pitm_pkg::CNT_BITS'(pitm_pkg::MAX_TETRAS)) ?
                pitm_pkg::CNT_BITS'(pitm_pkg::MAX_TETRAS) : tetra_count;
    end else if (cmd.idx_load) begin
      tidx <= tidx + 1'b1;
      remain <= remain - 1'b1;
    end
  end

  // stage 1: differences, point set per test
  pitm_pkg::point_t pa [5], pb [5], pc [5], pd [5];
  always_comb begin
    for (int t = 0; t < 5; t++) begin
      pa[t] = c0; pb[t] = c1; pc[t] = c2; pd[t] = vtx_rd;
    end
    pa[1] = qpt; pb[2] = qpt; pc[3] = qpt; pd[4] = qpt;
  end

  always_ff @(posedge clk) begin
    for (int t = 0; t < 5; t++) begin
      s1_bx[t] <= DB'(pb[t].x) - DB'(pd[t].x);
      s1_by[t] <= DB'(pb[t].y) - DB'(pd[t].y);
      s1_bz[t] <= DB'(pb[t].z) - DB'(pd[t].z);
      s1_cx[t] <= DB'(pc[t].x) - DB'(pd[t].x);
      s1_cy[t] <= DB'(pc[t].y) - DB'(pd[t].y);
      s1_cz[t] <= DB'(pc[t].z) - DB'(pd[t].z);
      s1_ax[t] <= DB'(pa[t].x) - DB'(pd[t].x);
      s1_ay[t] <= DB'(pa[t].y) - DB'(pd[t].y);
      s1_az[t] <= DB'(pa[t].z) - DB'(pd[t].z);
      s2_p[t][0] <= PB'(s1_bx[t]) * PB'(s1_cy[t]);
      s2_p[t][1] <= PB'(s1_by[t]) * PB'(s1_cx[t]);
      s2_p[t][2] <= PB'(s1_bz[t]) * PB'(s1_cx[t]);
      s2_p[t][3] <= PB'(s1_bx[t]) * PB'(s1_cz[t]);
      s2_p[t][4] <= PB'(s1_by[t]) * PB'(s1_cz[t]);
      s2_p[t][5] <= PB'(s1_bz[t]) * PB'(s1_cy[t]);
      s2_ax[t] <= s1_ax[t]; s2_ay[t] <= s1_ay[t]; s2_az[t] <= s1_az[t];
      s3_k[t][0] <= CB'(s2_p[t][0]) - CB'(s2_p[t][1]);
      s3_k[t][1] <= CB'(s2_p[t][2]) - CB'(s2_p[t][3]);
      s3_k[t][2] <= CB'(s2_p[t][4]) - CB'(s2_p[t][5]);
      s3_ax[t] <= s2_ax[t]; s3_ay[t] <= s2_ay[t]; s3_az[t] <= s2_az[t];
      s4_t[t][0] <= TB'(s3_k[t][0]) * TB'(s3_az[t]);
      s4_t[t][1] <= TB'(s3_k[t][1]) * TB'(s3_ay[t]);
      s4_t[t][2] <= TB'(s3_k[t][2]) * TB'(s3_ax[t]);
      s5_d[t] <= XB'(s4_t[t][0]) + XB'(s4_t[t][1]) + XB'(s4_t[t][2]);
    end
  end

  // valid timing: eval marks the beat when d is in vtx_rd; 5 more stages
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      vld <= {vld[NS-2:0], cmd.eval};
    end
  end

  logic [4:0] pos, neg, zer;
  logic hit;
  always_comb begin
    for (int t = 0; t < 5; t++) begin
      zer[t] = (s5_d[t] == '0);
      neg[t] = s5_d[t][XB-1];
      pos[t] = !zer[t] && !neg[t];
    end
    hit = (pos[0] && ((pos[4:1] | zer[4:1]) == 4'hf)) ||
          (neg[0] && ((neg[4:1] | zer[4:1]) == 4'hf));
  end

  always_ff @(posedge clk) begin
    if (rst || cmd.start) found <= 1'b0;
    else if (vld[4] && hit) found <= 1'b1;
  end

  assign status.busy = (vld != '0);
  assign status.done = (remain == '0);
  assign status.result = !found;
endmodule

// File: rtl/core/pitm_ctrl.sv
module pitm_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [1:0]           req_type,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic                 outside,
  input  pitm_pkg::status_t    status,
  output pitm_pkg::cmd_t       cmd
);
  typedef enum logic [7:0] {
    S_IDLE  = 8'b00000001,
    S_IDX   = 8'b00000010,
    S_TRD   = 8'b00000100,
    S_V0    = 8'b00001000,
    S_V1    = 8'b00010000,
    S_V2    = 8'b00100000,
    S_V3    = 8'b01000000,
    S_DRAIN = 8'b10000000
  } state_t;

  state_t state, state_next;
  logic acc;
  logic eval_d;

  assign in_ready = (state == S_IDLE) && !out_valid;
  assign acc = in_valid && in_ready;

  always_comb begin
    cmd = '0;
    state_next = state;
    cmd.vtx_wr = acc && (req_type == pitm_pkg::REQ_VERTEX);
    cmd.tet_wr = acc && (req_type == pitm_pkg::REQ_TETRA);
    cmd.start  = acc && (req_type == pitm_pkg::REQ_QUERY);
    cmd.eval   = eval_d;
    case (state)
      S_IDLE:  if (cmd.start) state_next = S_IDX;
      S_IDX:   state_next = status.done ? S_DRAIN : S_TRD;
      S_TRD:   state_next = S_V0;
      S_V0:    begin cmd.corner_sel = 2'd0; state_next = S_V1; end
      S_V1:    begin cmd.corner_sel = 2'd1; cmd.corner_fetch = 1'b1;
                 state_next = S_V2; end
      S_V2:    begin cmd.corner_sel = 2'd2; cmd.corner_fetch = 1'b1;
                 state_next = S_V3; end
      S_V3:    begin cmd.corner_sel = 2'd3; cmd.corner_fetch = 1'b1;
                 state_next = S_IDX; end
      S_DRAIN: if (!status.busy) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
    // tetra index advances as the tetra beat is read
    cmd.idx_load = (state == S_IDX) && !status.done;
  end

  // eval is raised in the cycle after V3, when d sits in the vertex read register
  always_ff @(posedge clk) begin
    if (rst) eval_d <= 1'b0;
    else eval_d <= (state == S_V3);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == S_DRAIN && !status.busy) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_DRAIN && !status.busy) outside <= status.result;
  end
endmodule

// File: rtl/core/point_in_tetra_mesh_test_top.sv
// channel | direction | handshake
// cfg     | in        | cfg_valid / cfg_ready
// in      | in        | in_valid / in_ready
// out     | out       | out_valid / out_ready
// writes go straight to the stores; a query steps, per tetra in use, through index, tetra
// read and four vertex reads on the single vertex port, then drains and presents the result
// reset clears control only; both stores are undefined until written
// input is held off while a query runs or its result waits
module point_in_tetra_mesh_test_top (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [pitm_pkg::CNT_BITS-1:0] cfg_data,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [1:0]                    req_type,
  input  logic [11:0]                   entry_index,
  input  logic signed [15:0]            x_coord,
  input  logic signed [15:0]            y_coord,
  input  logic signed [15:0]            z_coord,
  input  logic [11:0]                   corner_a,
  input  logic [11:0]                   corner_b,
  input  logic [11:0]                   corner_c,
  input  logic [11:0]                   corner_d,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic                          outside
);
`include "assert_macros.svh"
  logic [pitm_pkg::CNT_BITS-1:0] tetra_count;
  pitm_pkg::cmd_t cmd;
  pitm_pkg::status_t status;
  pitm_pkg::point_t pt;

  assign cfg_ready = 1'b1;
  assign pt = '{x: x_coord, y: y_coord, z: z_coord};

  always_ff @(posedge clk) begin
    if (rst) tetra_count <= '0;
    else if (cfg_valid) tetra_count <= cfg_data;
  end

  pitm_ctrl u_ctrl (
    .clk, .rst, .in_valid, .in_ready, .req_type, .out_valid, .out_ready,
    .outside, .status, .cmd
  );

  pitm_datapath u_dp (
    .clk, .rst, .cmd, .entry_index, .pt_in(pt),
    .corners_in({corner_a, corner_b, corner_c, corner_d}),
    .tetra_count, .status
  );

  `ASSERT_NEVER(a_no_accept_busy, clk, rst, in_ready && out_valid)
  `ASSERT_IMPL(a_out_after_drain, clk, rst, $rose(out_valid) |-> !status.busy)
  `ASSERT_NEVER(a_one_write, clk, rst, cmd.vtx_wr && cmd.tet_wr)
endmodule
